// ===== design/mcfe_pkg.sv =====
// Shared types and constants for the motor command frame encoder.
// No dependencies.
package mcfe_pkg;

    localparam int LANES     = 5;
    localparam int DIV_STEPS = 16;
    localparam int FIFO_AW   = 2;

    typedef enum logic [1:0] {
        KIND_CTRL  = 2'd0,
        KIND_MOTOR = 2'd1,
        KIND_RESET = 2'd2,
        KIND_ZERO  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        REG_MOTOR_ID  = 3'd0,
        REG_POS_MIN   = 3'd1,
        REG_POS_MAX   = 3'd2,
        REG_VEL_LIM   = 3'd3,
        REG_KP_MAX    = 3'd4,
        REG_KD_MAX    = 3'd5,
        REG_TRQ_LIM   = 3'd6
    } t_reg;

    localparam logic [10:0] RST_MOTOR_ID = 11'd1;
    localparam logic [31:0] RST_POS_MIN  = 32'hFFF3_8000;
    localparam logic [31:0] RST_POS_MAX  = 32'h000C_8000;
    localparam logic [30:0] RST_VEL_LIM  = 31'd2949120;
    localparam logic [30:0] RST_KP_MAX   = 31'd32768000;
    localparam logic [30:0] RST_KD_MAX   = 31'd327680;
    localparam logic [30:0] RST_TRQ_LIM  = 31'd1179648;

    localparam logic [7:0]  BYTE_FILL  = 8'hFF;
    localparam logic [7:0]  BYTE_MOTOR = 8'hFC;
    localparam logic [7:0]  BYTE_RESET = 8'hFD;
    localparam logic [7:0]  BYTE_ZERO  = 8'hFE;

    typedef struct packed {
        logic signed [31:0] pos_min;
        logic signed [31:0] pos_max;
        logic [30:0]        vel_lim;
        logic [30:0]        kp_max;
        logic [30:0]        kd_max;
        logic [30:0]        trq_lim;
    } t_cfg;

    // One quantiser lane: clamped offset, range span and a valid-range flag
    typedef struct packed {
        logic        ok;
        logic [32:0] d;
        logic [32:0] span;
    } t_lane;

    typedef struct packed {
        t_kind               kind;
        t_lane [LANES-1:0]   lane;
    } t_item;

endpackage

// ===== design/motor_command_frame_encoder_core.sv =====
// Motor command frame encoder: front register, queue, then divider pipeline.
// Throughput one transaction per cycle while the output is taken and the queue has room;
// the 16-stage divider pipeline per lane follows a 4-entry queue that decouples front from back.
// Reset is synchronous, active low: clears valids and the queue and loads
// the register defaults. No clearing pass.
module motor_command_frame_encoder_core import mcfe_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_kind,
    input  logic signed [31:0] i_position,
    input  logic signed [31:0] i_velocity,
    input  logic signed [31:0] i_kp_gain,
    input  logic signed [31:0] i_kd_gain,
    input  logic signed [31:0] i_torque,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [10:0]        o_can_id,
    output logic [63:0]        o_frame
);

    logic [10:0]      r_motor_id;
    t_cfg             r_cfg;
    logic             push;
    t_item            f_item;
    logic             q_valid;
    t_item            q_item;
    logic             pop;
    logic [FIFO_AW:0] q_count;
    logic             room;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motor_id    <= RST_MOTOR_ID;
            r_cfg.pos_min <= RST_POS_MIN;
            r_cfg.pos_max <= RST_POS_MAX;
            r_cfg.vel_lim <= RST_VEL_LIM;
            r_cfg.kp_max  <= RST_KP_MAX;
            r_cfg.kd_max  <= RST_KD_MAX;
            r_cfg.trq_lim <= RST_TRQ_LIM;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MOTOR_ID: r_motor_id    <= i_cfg_data[10:0];
                REG_POS_MIN:  r_cfg.pos_min <= i_cfg_data;
                REG_POS_MAX:  r_cfg.pos_max <= i_cfg_data;
                REG_VEL_LIM:  r_cfg.vel_lim <= i_cfg_data[30:0];
                REG_KP_MAX:   r_cfg.kp_max  <= i_cfg_data[30:0];
                REG_KD_MAX:   r_cfg.kd_max  <= i_cfg_data[30:0];
                REG_TRQ_LIM:  r_cfg.trq_lim <= i_cfg_data[30:0];
                default:      ;
            endcase
        end
    end

    // Accept only with a queue slot reserved for the front register
    assign room = ((q_count + (FIFO_AW+1)'(push)) < (FIFO_AW+1)'(1 << FIFO_AW));

    mcfe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (i_valid),
        .i_room     (room),
        .i_kind     (i_kind),
        .i_position (i_position),
        .i_velocity (i_velocity),
        .i_kp_gain  (i_kp_gain),
        .i_kd_gain  (i_kd_gain),
        .i_torque   (i_torque),
        .o_ready    (o_ready),
        .o_push     (push),
        .o_item     (f_item)
    );

    mcfe_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item),
        .o_count (q_count)
    );

    mcfe_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (q_valid),
        .i_item  (q_item),
        .o_pop   (pop),
        .i_ready (i_ready),
        .o_valid (o_valid),
        .o_frame (o_frame)
    );

    assign o_can_id = r_motor_id;

endmodule

// ===== design/mcfe_front.sv =====
// Front end: accepts command transactions, clamps each value to its range.
// Depends on mcfe_pkg.
module mcfe_front import mcfe_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_valid,
    input  logic               i_room,
    input  logic [1:0]         i_kind,
    input  logic signed [31:0] i_position,
    input  logic signed [31:0] i_velocity,
    input  logic signed [31:0] i_kp_gain,
    input  logic signed [31:0] i_kd_gain,
    input  logic signed [31:0] i_torque,
    output logic               o_ready,
    output logic               o_push,
    output t_item              o_item
);

    logic  r_fv;
    t_item r_item;
    t_item n_item;

    function automatic t_lane clamp_lane(input logic signed [33:0] x,
                                         input logic signed [33:0] lo,
                                         input logic signed [33:0] hi);
        t_lane              l;
        logic signed [33:0] xc;
        logic signed [33:0] d;
        logic signed [33:0] s;
        xc = (x < lo) ? lo : ((x > hi) ? hi : x);
        d  = xc - lo;
        s  = hi - lo;
        l.ok   = (hi > lo);
        l.d    = d[32:0];
        l.span = s[32:0];
        return l;
    endfunction

    assign o_ready = i_room;

    // Classify and clamp
    always_comb begin
        n_item.kind    = t_kind'(i_kind);
        n_item.lane[0] = clamp_lane(34'(i_position), 34'(i_cfg.pos_min), 34'(i_cfg.pos_max));
        n_item.lane[1] = clamp_lane(34'(i_velocity), -$signed({3'b000, i_cfg.vel_lim}),
                                    $signed({3'b000, i_cfg.vel_lim}));
        n_item.lane[2] = clamp_lane(34'(i_kp_gain), 34'sd0, $signed({3'b000, i_cfg.kp_max}));
        n_item.lane[3] = clamp_lane(34'(i_kd_gain), 34'sd0, $signed({3'b000, i_cfg.kd_max}));
        n_item.lane[4] = clamp_lane(34'(i_torque), -$signed({3'b000, i_cfg.trq_lim}),
                                    $signed({3'b000, i_cfg.trq_lim}));
    end

    // Register the classified transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else begin
            r_fv <= i_valid && i_room;
        end
        if (i_valid && i_room) begin
            r_item <= n_item;
        end
    end

    assign o_push = r_fv;
    assign o_item = r_item;

endmodule

// ===== design/mcfe_fifo.sv =====
// Short queue between front and back ends, with a credit count for the front.
// Depends on mcfe_pkg.
module mcfe_fifo import mcfe_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_item  i_item,
    input  logic   i_pop,
    output logic   o_valid,
    output t_item  o_item,
    output logic [FIFO_AW:0] o_count
);

    t_item              r_mem [0:(1<<FIFO_AW)-1];
    logic [FIFO_AW-1:0] r_wp;
    logic [FIFO_AW-1:0] r_rp;
    logic [FIFO_AW:0]   r_cnt;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (FIFO_AW+1)'(i_push) - (FIFO_AW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    assign o_count = r_cnt;

endmodule

// ===== design/mcfe_back.sv =====
// Back end: pipelined restoring division per lane, then frame packing.
// Depends on mcfe_pkg.
module mcfe_back import mcfe_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_avail,
    input  t_item        i_item,
    output logic         o_pop,
    input  logic         i_ready,
    output logic         o_valid,
    output logic [63:0]  o_frame
);

    logic        r_v    [0:DIV_STEPS];
    t_kind       r_kind [0:DIV_STEPS];
    logic        r_ok   [0:DIV_STEPS][0:LANES-1];
    logic [32:0] r_rem  [0:DIV_STEPS][0:LANES-1];
    logic [32:0] r_den  [0:DIV_STEPS][0:LANES-1];
    logic [15:0] r_low  [0:DIV_STEPS][0:LANES-1];
    logic [15:0] r_q    [0:DIV_STEPS][0:LANES-1];
    logic        en;
    logic [11:0] code [1:LANES-1];
    logic [15:0] pcode;
    logic [7:0]  last_byte;

    // Whole pipeline holds while the result is not taken
    assign en    = !(r_v[DIV_STEPS] && !i_ready);
    assign o_pop = en && i_avail;

    // Stage zero: form numerator d * (2^bits - 1)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_avail;
        end
        if (en) begin
            r_kind[0] <= i_item.kind;
            for (int l = 0; l < LANES; l++) begin
                logic [48:0] num;
                if (l == 0) begin
                    num = {i_item.lane[l].d, 16'h0000} - {16'h0000, i_item.lane[l].d};
                end else begin
                    num = {4'h0, i_item.lane[l].d, 12'h000} - {16'h0000, i_item.lane[l].d};
                end
                r_ok[0][l]  <= i_item.lane[l].ok;
                r_den[0][l] <= i_item.lane[l].span;
                r_rem[0][l] <= num[48:16];
                r_low[0][l] <= num[15:0];
                r_q[0][l]   <= '0;
            end
        end
    end

    // One quotient bit per stage
    for (genvar s = 1; s <= DIV_STEPS; s++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (en) begin
                r_v[s] <= r_v[s-1];
            end
            if (en) begin
                r_kind[s] <= r_kind[s-1];
                for (int l = 0; l < LANES; l++) begin
                    logic [33:0] t;
                    t = {r_rem[s-1][l], r_low[s-1][l][15]};
                    r_ok[s][l]  <= r_ok[s-1][l];
                    r_den[s][l] <= r_den[s-1][l];
                    r_low[s][l] <= {r_low[s-1][l][14:0], 1'b0};
                    if (t >= {1'b0, r_den[s-1][l]}) begin
                        r_rem[s][l] <= 33'(t - {1'b0, r_den[s-1][l]});
                        r_q[s][l]   <= {r_q[s-1][l][14:0], 1'b1};
                    end else begin
                        r_rem[s][l] <= t[32:0];
                        r_q[s][l]   <= {r_q[s-1][l][14:0], 1'b0};
                    end
                end
            end
        end
    end

    // Pack codes or the mode frame
    always_comb begin
        pcode = r_ok[DIV_STEPS][0] ? r_q[DIV_STEPS][0] : 16'h0000;
        for (int l = 1; l < LANES; l++) begin
            code[l] = r_ok[DIV_STEPS][l] ? r_q[DIV_STEPS][l][11:0] : 12'h000;
        end
        unique case (r_kind[DIV_STEPS])
            KIND_MOTOR: last_byte = BYTE_MOTOR;
            KIND_RESET: last_byte = BYTE_RESET;
            default:    last_byte = BYTE_ZERO;
        endcase
        if (r_kind[DIV_STEPS] == KIND_CTRL) begin
            o_frame = {pcode, code[1], code[2], code[3], code[4]};
        end else begin
            o_frame = {{7{BYTE_FILL}}, last_byte};
        end
    end

    assign o_valid = r_v[DIV_STEPS];

endmodule
